// ===== rtl/wia_pkg.sv =====
// wia_pkg: opcodes, status codes and pipeline stage types of the
// webassembly integer alu; no dependencies
package wia_pkg;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIVU  = 4'd3,
    OP_DIVS  = 4'd4,
    OP_REMU  = 4'd5,
    OP_REMS  = 4'd6,
    OP_AND   = 4'd7,
    OP_OR    = 4'd8,
    OP_XOR   = 4'd9,
    OP_SHL   = 4'd10,
    OP_SHRU  = 4'd11,
    OP_SHRS  = 4'd12,
    OP_ROTL  = 4'd13,
    OP_ROTR  = 4'd14,
    OP_NONE  = 4'd15
  } op_e;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIVZERO  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam int unsigned XLEN = 64;
  localparam int unsigned DIV_STAGES = XLEN;

  typedef struct packed {
    logic            valid;
    op_e             op;
    logic            wide;
    logic            sa;
    logic            sb;
    logic [1:0]      status;
    logic [XLEN-1:0] res;
    logic [XLEN-1:0] r;
    logic [XLEN-1:0] nq;
    logic [XLEN-1:0] d;
  } div_stage_t;

endpackage

// ===== rtl/wasm_integer_alu_top.sv =====
// wasm_integer_alu_top: pipelined i32/i64 integer binary alu with a
// one-bit-per-stage divider; depends on wia_pkg
//
// One item enters per cycle while the pipeline advances; its result passes through the
// input register, operand and partial product stage, product merge stage, 64 restoring
// divide stages and output register. Every opcode goes through the 64-stage divider
// so results stay in order. The whole pipeline advances whenever the output register
// is empty or being taken.
module wasm_integer_alu_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,   // lhs[63:0], rhs[127:64]
  input  logic [4:0]   s_axis_tuser_i,   // op[3:0], wide[4]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o,   // value[63:0]
  output logic [1:0]   m_axis_tuser_o    // status[1:0]
);

  localparam int unsigned W = wia_pkg::XLEN;
  localparam int unsigned H = W / 2;

  logic en;
  logic out_valid_q;
  logic [W-1:0] out_value_q;
  logic [1:0] out_status_q;

  assign en = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // stage a: masked operands
  logic         va_q;
  wia_pkg::op_e opa_q;
  logic         widea_q;
  logic [W-1:0] aa_q, ba_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      opa_q   <= wia_pkg::op_e'(s_axis_tuser_i[3:0]);
      widea_q <= s_axis_tuser_i[4];
      aa_q    <= s_axis_tuser_i[4] ? s_axis_tdata_i[W-1:0]
                                   : {{H{1'b0}}, s_axis_tdata_i[H-1:0]};
      ba_q    <= s_axis_tuser_i[4] ? s_axis_tdata_i[2*W-1:W]
                                   : {{H{1'b0}}, s_axis_tdata_i[W+H-1:W]};
    end
  end

  // stage b: simple ops, signs, status, partial products
  logic [W-1:0] mask_a, top_a, ext_a, ma_d, mb_d, res_d;
  logic [5:0]   k_a;
  logic         sa_d, sb_d;
  logic [1:0]   st_d;
  logic [2*W-1:0] rotl_w, rotr_w;

  always_comb begin
    mask_a = widea_q ? {W{1'b1}} : {{H{1'b0}}, {H{1'b1}}};
    top_a  = widea_q ? {1'b1, {(W-1){1'b0}}} : {{H{1'b0}}, 1'b1, {(H-1){1'b0}}};
    k_a    = widea_q ? ba_q[5:0] : {1'b0, ba_q[4:0]};
    sa_d   = (aa_q & top_a) != '0;
    sb_d   = (ba_q & top_a) != '0;
    ma_d   = sa_d ? ((~aa_q + W'(1)) & mask_a) : aa_q;
    mb_d   = sb_d ? ((~ba_q + W'(1)) & mask_a) : ba_q;
    ext_a  = widea_q ? aa_q : {{H{aa_q[H-1]}}, aa_q[H-1:0]};
    rotl_w = widea_q ? ({aa_q, aa_q} << k_a)
                     : {{W{1'b0}}, ({aa_q[H-1:0], aa_q[H-1:0]} << k_a)};
    rotr_w = widea_q ? ({aa_q, aa_q} >> k_a)
                     : {{W{1'b0}}, ({aa_q[H-1:0], aa_q[H-1:0]} >> k_a)};
    st_d = wia_pkg::ST_OK;
    if ((opa_q == wia_pkg::OP_DIVU || opa_q == wia_pkg::OP_DIVS ||
         opa_q == wia_pkg::OP_REMU || opa_q == wia_pkg::OP_REMS) && ba_q == '0) begin
      st_d = wia_pkg::ST_DIVZERO;
    end else if (opa_q == wia_pkg::OP_DIVS && aa_q == top_a && ba_q == mask_a) begin
      st_d = wia_pkg::ST_OVERFLOW;
    end
    case (opa_q)
      wia_pkg::OP_ADD:  res_d = aa_q + ba_q;
      wia_pkg::OP_SUB:  res_d = aa_q - ba_q;
      wia_pkg::OP_AND:  res_d = aa_q & ba_q;
      wia_pkg::OP_OR:   res_d = aa_q | ba_q;
      wia_pkg::OP_XOR:  res_d = aa_q ^ ba_q;
      wia_pkg::OP_SHL:  res_d = aa_q << k_a;
      wia_pkg::OP_SHRU: res_d = aa_q >> k_a;
      wia_pkg::OP_SHRS: res_d = W'($signed(ext_a) >>> k_a);
      wia_pkg::OP_ROTL: res_d = widea_q ? rotl_w[2*W-1:W] : {{H{1'b0}}, rotl_w[W-1:H]};
      wia_pkg::OP_ROTR: res_d = widea_q ? rotr_w[W-1:0] : {{H{1'b0}}, rotr_w[H-1:0]};
      default:          res_d = '0;
    endcase
    res_d = res_d & mask_a;
  end

  logic         vb_q, wideb_q, sab_q, sbb_q;
  wia_pkg::op_e opb_q;
  logic [1:0]   stb_q;
  logic [W-1:0] ab_q, bb_q, mab_q, mbb_q, resb_q, pll_q;
  logic [H-1:0] plh_q, phl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      opb_q   <= opa_q;
      wideb_q <= widea_q;
      sab_q   <= sa_d;
      sbb_q   <= sb_d;
      stb_q   <= st_d;
      ab_q    <= aa_q;
      bb_q    <= ba_q;
      mab_q   <= ma_d;
      mbb_q   <= mb_d;
      resb_q  <= res_d;
      pll_q   <= W'(aa_q[H-1:0]) * W'(ba_q[H-1:0]);
      plh_q   <= H'(aa_q[H-1:0] * ba_q[W-1:H]);
      phl_q   <= H'(aa_q[W-1:H] * ba_q[H-1:0]);
    end
  end

  // stage c: product merge, divider operands
  wia_pkg::div_stage_t dv_q [0:wia_pkg::DIV_STAGES];
  wia_pkg::div_stage_t dv_d [0:wia_pkg::DIV_STAGES];
  logic [W-1:0] prod_c;
  logic         sgn_c;

  always_comb begin
    prod_c = pll_q + {plh_q + phl_q, {H{1'b0}}};
    if (!wideb_q) prod_c = {{H{1'b0}}, prod_c[H-1:0]};
    sgn_c = (opb_q == wia_pkg::OP_DIVS) || (opb_q == wia_pkg::OP_REMS);
    dv_d[0].valid  = vb_q;
    dv_d[0].op     = opb_q;
    dv_d[0].wide   = wideb_q;
    dv_d[0].sa     = sab_q;
    dv_d[0].sb     = sbb_q;
    dv_d[0].status = stb_q;
    dv_d[0].res    = (opb_q == wia_pkg::OP_MUL) ? prod_c : resb_q;
    dv_d[0].r      = '0;
    dv_d[0].nq     = sgn_c ? mab_q : ab_q;
    dv_d[0].d      = sgn_c ? mbb_q : bb_q;
  end

  genvar gi;
  generate
    for (gi = 0; gi < wia_pkg::DIV_STAGES; gi++) begin : g_div
      logic [W:0] r2, diff;
      always_comb begin
        r2   = {dv_q[gi].r, dv_q[gi].nq[W-1]};
        diff = r2 - {1'b0, dv_q[gi].d};
        dv_d[gi+1] = dv_q[gi];
        if (!diff[W]) begin
          dv_d[gi+1].r  = diff[W-1:0];
          dv_d[gi+1].nq = {dv_q[gi].nq[W-2:0], 1'b1};
        end else begin
          dv_d[gi+1].r  = r2[W-1:0];
          dv_d[gi+1].nq = {dv_q[gi].nq[W-2:0], 1'b0};
        end
      end
    end
    for (gi = 0; gi <= wia_pkg::DIV_STAGES; gi++) begin : g_reg
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          dv_q[gi].valid <= 1'b0;
        end else if (en) begin
          dv_q[gi] <= dv_d[gi];
        end
      end
    end
  endgenerate

  // output stage: sign fix and select
  wia_pkg::div_stage_t lst;
  logic [W-1:0] mask_o, q_neg, r_neg, val_d;

  always_comb begin
    lst    = dv_q[wia_pkg::DIV_STAGES];
    mask_o = lst.wide ? {W{1'b1}} : {{H{1'b0}}, {H{1'b1}}};
    q_neg  = (~lst.nq + W'(1)) & mask_o;
    r_neg  = (~lst.r + W'(1)) & mask_o;
    case (lst.op)
      wia_pkg::OP_DIVU: val_d = lst.nq;
      wia_pkg::OP_DIVS: val_d = (lst.sa ^ lst.sb) ? q_neg : lst.nq;
      wia_pkg::OP_REMU: val_d = lst.r;
      wia_pkg::OP_REMS: val_d = lst.sa ? r_neg : lst.r;
      default:          val_d = lst.res;
    endcase
    if (lst.status != wia_pkg::ST_OK) val_d = '0;
    val_d = val_d & mask_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= lst.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_value_q  <= val_d;
      out_status_q <= lst.status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_status_q;

  // checks
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o != 2'd3))
    else $error("status code out of range");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != wia_pkg::ST_OK) |-> (m_axis_tdata_o == '0))
    else $error("error item with nonzero value");

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output stage");

endmodule
